FILE: rtl/core/matrix_multiply_defines.svh
// Assertion macros for the matrix multiplier
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH
`ifndef SYNTHESIS
`define MM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("matrix multiplier check failed");
`define MM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("matrix multiplier check failed");
`else
`define MM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/mm_pkg.sv
// Shared types and constants of the matrix multiplier
package mm_pkg;

  localparam int ROW_BITS     = 3;
  localparam int COL_BITS     = 3;
  localparam int VAL_BITS     = 35;
  localparam int DIM_BITS     = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [DIM_BITS-1:0] RESET_DIM = 4'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_B_COLS    = 2'd2;

  localparam logic FUNC_LOAD_A = 1'b0;
  localparam logic FUNC_LOAD_B = 1'b1;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/mm_intf.sv
// Input and output channel interfaces of the matrix multiplier
interface mm_in_if #(
  parameter int ELEM_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [ELEM_BITS-1:0] elem_value;

  modport source (output valid, func, elem_value, input ready);
  modport sink   (input valid, func, elem_value, output ready);
endinterface

interface mm_out_if import mm_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [ROW_BITS-1:0]        out_row;
  logic [COL_BITS-1:0]        out_col;
  logic signed [VAL_BITS-1:0] out_value;
  logic                       out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

FILE: rtl/core/mm_mem.sv
// Single write port, single registered read port element store
module mm_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mm_mac.sv
// Shared multiply-accumulate unit: multiply stage then accumulate stage
module mm_mac import mm_pkg::*; #(
  parameter int ELEM_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_ctrl_t                   ctrl_i,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic signed [ELEM_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [VAL_BITS-1:0]  acc_o
);

  mac_ctrl_t                     ctrl1_q, ctrl2_q;
  logic                          done_q;
  logic signed [2*ELEM_BITS-1:0] prod_d, prod_q;
  logic signed [VAL_BITS-1:0]    acc_d, acc_q;

  // store read data lines up with ctrl1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      done_q  <= ctrl2_q.issue && ctrl2_q.last;
    end
  end

  assign prod_d = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl2_q.issue) begin
      if (ctrl2_q.first) begin
        acc_d = VAL_BITS'(prod_q);
      end else begin
        acc_d = acc_q + VAL_BITS'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl1_q.issue) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

FILE: rtl/core/mm_seq.sv
// Sequencer: configuration, load counters and the row/column/inner walk
`include "matrix_multiply_defines.svh"

module mm_seq import mm_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int DEPTH   = 64,
  parameter int AW      = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [DIM_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_func_i,
  output logic                    a_we_o,
  output logic                    b_we_o,
  output logic [AW-1:0]           waddr_o,
  output logic [AW-1:0]           a_raddr_o,
  output logic [AW-1:0]           b_raddr_o,
  output mac_ctrl_t               ctrl_o,
  input  logic                    mac_done_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ROW_BITS-1:0]     out_row_o,
  output logic [COL_BITS-1:0]     out_col_o,
  output logic                    out_last_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  state_e              state_d, state_q;
  logic [DIM_BITS-1:0] rows_cfg_q, inner_cfg_q, cols_cfg_q;
  logic [CNT_W-1:0]    a_cnt_d, a_cnt_q, b_cnt_d, b_cnt_q;
  logic [IDX_W-1:0]    r_d, r_q, c_d, c_q, k_d, k_q;
  logic [AW-1:0]       a_base_d, a_base_q, a_addr_d, a_addr_q, b_addr_d, b_addr_q;
  logic [DIM_W-1:0]    rows, inner, cols;
  logic [CNT_W-1:0]    a_total, b_total;
  logic [IDX_W-1:0]    r_end, c_end, k_end;
  logic [AW-1:0]       next_base;
  logic                accept, a_we, b_we, row_end, col_end;

  assign rows    = eff_dim(rows_cfg_q);
  assign inner   = eff_dim(inner_cfg_q);
  assign cols    = eff_dim(cols_cfg_q);
  assign a_total = CNT_W'(rows) * CNT_W'(inner);
  assign b_total = CNT_W'(inner) * CNT_W'(cols);
  assign r_end   = IDX_W'(rows - DIM_W'(1));
  assign c_end   = IDX_W'(cols - DIM_W'(1));
  assign k_end   = IDX_W'(inner - DIM_W'(1));
  assign row_end = (r_q == r_end);
  assign col_end = (c_q == c_end);

  assign next_base = a_base_q + AW'(inner);

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign a_we       = accept && (in_func_i == FUNC_LOAD_A) && (a_cnt_q < a_total);
  assign b_we       = accept && (in_func_i == FUNC_LOAD_B) && (b_cnt_q < b_total);
  assign a_we_o     = a_we;
  assign b_we_o     = b_we;
  assign waddr_o    = (in_func_i == FUNC_LOAD_A) ? a_cnt_q[AW-1:0] : b_cnt_q[AW-1:0];

  assign a_raddr_o    = a_addr_q;
  assign b_raddr_o    = b_addr_q;
  assign ctrl_o.issue = (state_q == ST_ISSUE);
  assign ctrl_o.first = (k_q == '0);
  assign ctrl_o.last  = (k_q == k_end);

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_row_o   = ROW_BITS'(r_q);
  assign out_col_o   = COL_BITS'(c_q);
  assign out_last_o  = row_end && col_end;

  always_comb begin
    state_d  = state_q;
    a_cnt_d  = a_cnt_q + CNT_W'(a_we);
    b_cnt_d  = b_cnt_q + CNT_W'(b_we);
    r_d      = r_q;
    c_d      = c_q;
    k_d      = k_q;
    a_base_d = a_base_q;
    a_addr_d = a_addr_q;
    b_addr_d = b_addr_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && (a_cnt_d >= a_total) && (b_cnt_d >= b_total)) begin
          state_d  = ST_ISSUE;
          r_d      = '0;
          c_d      = '0;
          k_d      = '0;
          a_base_d = '0;
          a_addr_d = '0;
          b_addr_d = '0;
        end
      end
      ST_ISSUE: begin
        k_d      = k_q + IDX_W'(1);
        a_addr_d = a_addr_q + AW'(1);
        b_addr_d = b_addr_q + AW'(cols);
        if (k_q == k_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          k_d = '0;
          if (col_end && row_end) begin
            state_d = ST_LOAD;
            a_cnt_d = '0;
            b_cnt_d = '0;
          end else if (col_end) begin
            state_d  = ST_ISSUE;
            r_d      = r_q + IDX_W'(1);
            c_d      = '0;
            a_base_d = next_base;
            a_addr_d = next_base;
            b_addr_d = '0;
          end else begin
            state_d  = ST_ISSUE;
            c_d      = c_q + IDX_W'(1);
            a_addr_d = a_base_q;
            b_addr_d = AW'(c_q + IDX_W'(1));
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      rows_cfg_q  <= RESET_DIM;
      inner_cfg_q <= RESET_DIM;
      cols_cfg_q  <= RESET_DIM;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      a_base_q    <= '0;
      a_addr_q    <= '0;
      b_addr_q    <= '0;
    end else begin
      state_q  <= state_d;
      a_cnt_q  <= a_cnt_d;
      b_cnt_q  <= b_cnt_d;
      r_q      <= r_d;
      c_q      <= c_d;
      k_q      <= k_d;
      a_base_q <= a_base_d;
      a_addr_q <= a_addr_d;
      b_addr_q <= b_addr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_A_ROWS:    rows_cfg_q  <= cfg_data_i;
          CFG_INNER_DIM: inner_cfg_q <= cfg_data_i;
          CFG_B_COLS:    cols_cfg_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  `MM_ASSERT_IMPL(a_mac_done_in_drain, clk_i, rst_ni, mac_done_i, state_q == ST_DRAIN)
  `MM_ASSERT_IMPL(a_k_in_range, clk_i, rst_ni, state_q == ST_ISSUE, k_q <= k_end)
  `MM_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, out_valid_o && out_ready_i && out_last_o, state_q == ST_LOAD && a_cnt_q == '0 && b_cnt_q == '0)
  `MM_ASSERT_NEXT(a_emit_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, state_q == ST_EMIT && $stable(r_q) && $stable(c_q))

endmodule

FILE: rtl/core/matrix_multiply.sv
// Matrix multiplier top level: P = A * B over signed Q8.8 elements
//
// Input channel in_i: one beat per element, func selects A or B, elements of
// each matrix in row-major order. Loading takes one beat per cycle. Elements
// beyond a complete matrix are dropped.
// Configuration: cfg_we_i writes a_rows, inner_dim or b_cols (index 0..2).
// The user is to write them only while the block is idle; the block does not
// enforce it. 0 acts as 1, values above MAX_DIM as MAX_DIM. After the beat
// that completes both matrices, in_i.ready drops and the block walks the
// product row-major. Each element goes in turn through the one shared
// multiply-accumulate unit (one store read per cycle, then a multiply stage
// and an accumulate stage) and is emitted before the next is issued.
// Output channel out_o: row, column, exact Q19.16 value and last mark; the
// beat is held until taken and nothing advances meanwhile.
// After the last element the load counters clear and in_i.ready returns.
// Reset: load counters cleared, dimensions 4; stores are not cleared.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  mm_in_if.sink                   in_i,
  mm_out_if.source                out_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [DIM_BITS-1:0]     cfg_data_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 a_we, b_we, mac_done;
  logic [AW-1:0]        waddr, a_raddr, b_raddr;
  logic [ELEM_BITS-1:0] a_rdata, b_rdata;
  mac_ctrl_t            mac_ctrl;

  mm_seq #(
    .MAX_DIM (MAX_DIM),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_func_i   (in_i.func),
    .a_we_o      (a_we),
    .b_we_o      (b_we),
    .waddr_o     (waddr),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .ctrl_o      (mac_ctrl),
    .mac_done_i  (mac_done),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .out_last_o  (out_o.out_last)
  );

  mm_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS),
    .AW    (AW)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (in_i.elem_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS),
    .AW    (AW)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (in_i.elem_value),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    ($signed(a_rdata)),
    .b_i    ($signed(b_rdata)),
    .done_o (mac_done),
    .acc_o  (out_o.out_value)
  );

endmodule

FILE: dv/mm_checker.sv
// Beat monitor, product predictor and result comparison for the matrix multiplier
module mm_checker import mm_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       in_func_i,
  input  logic [ELEM_BITS-1:0]       in_elem_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [ROW_BITS-1:0]        out_row_i,
  input  logic [COL_BITS-1:0]        out_col_i,
  input  logic signed [VAL_BITS-1:0] out_value_i,
  input  logic                       out_last_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [DIM_BITS-1:0]        cfg_data_i,
  output int unsigned                errors_o,
  output int unsigned                pending_o,
  output int unsigned                stored_o,
  output int unsigned                products_o,
  output int unsigned                beats_o
);

  typedef struct packed {
    logic [ROW_BITS-1:0]        row;
    logic [COL_BITS-1:0]        col;
    logic signed [VAL_BITS-1:0] value;
    logic                       last;
  } prod_elem_t;

  prod_elem_t           expected_q[$];
  logic [DIM_BITS-1:0]  rows_q, inner_q, cols_q;
  logic [ELEM_BITS-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [ELEM_BITS-1:0] b_mem [MAX_DIM*MAX_DIM];
  int unsigned          a_cnt, b_cnt;
  int unsigned          n_err, n_stored, n_prod, n_beats;

  function automatic int unsigned span(input logic [DIM_BITS-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  task automatic predict_product();
    int unsigned                  rows, inner, cols;
    logic signed [63:0]           acc;
    logic signed [ELEM_BITS-1:0]  x, y;
    logic signed [2*ELEM_BITS-1:0] p;
    prod_elem_t                   e;
    rows  = span(rows_q);
    inner = span(inner_q);
    cols  = span(cols_q);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        acc = '0;
        for (int unsigned k = 0; k < inner; k++) begin
          x   = a_mem[r*inner + k];
          y   = b_mem[k*cols + c];
          p   = x * y;
          acc = acc + p;
        end
        e.row   = ROW_BITS'(r);
        e.col   = COL_BITS'(c);
        e.value = acc[VAL_BITS-1:0];
        e.last  = (r == rows - 1) && (c == cols - 1);
        expected_q.push_back(e);
      end
    end
    a_cnt = 0;
    b_cnt = 0;
    n_prod++;
  endtask

  task automatic take_elem(input logic f, input logic [ELEM_BITS-1:0] v);
    int unsigned a_total, b_total;
    a_total = span(rows_q) * span(inner_q);
    b_total = span(inner_q) * span(cols_q);
    if (f == FUNC_LOAD_A) begin
      if (a_cnt < a_total) begin
        a_mem[a_cnt] = v;
        a_cnt++;
        n_stored++;
      end
    end else begin
      if (b_cnt < b_total) begin
        b_mem[b_cnt] = v;
        b_cnt++;
        n_stored++;
      end
    end
    // completion is also reached when a shrunk dimension leaves a matrix overfull
    if (a_cnt >= a_total && b_cnt >= b_total) predict_product();
  endtask

  task automatic check_beat();
    prod_elem_t e;
    n_beats++;
    if (expected_q.size() == 0) begin
      n_err++;
      if (n_err <= 10)
        $display("unexpected result beat: row %0d col %0d value %0d last %0b",
                 out_row_i, out_col_i, out_value_i, out_last_i);
    end else begin
      e = expected_q.pop_front();
      if (e.row !== out_row_i || e.col !== out_col_i || e.value !== out_value_i ||
          e.last !== out_last_i) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: exp row %0d col %0d value %0d last %0b, got %0d %0d %0d %0b",
                   e.row, e.col, $signed(e.value), e.last,
                   out_row_i, out_col_i, out_value_i, out_last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      rows_q   = RESET_DIM;
      inner_q  = RESET_DIM;
      cols_q   = RESET_DIM;
      a_cnt    = 0;
      b_cnt    = 0;
      n_err    = 0;
      n_stored = 0;
      n_prod   = 0;
      n_beats  = 0;
    end else begin
      if (in_valid_i && in_ready_i) take_elem(in_func_i, in_elem_i);
      if (out_valid_i && out_ready_i) check_beat();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_A_ROWS:    rows_q  = cfg_data_i;
          CFG_INNER_DIM: inner_q = cfg_data_i;
          CFG_B_COLS:    cols_q  = cfg_data_i;
          default: ;
        endcase
      end
    end
    errors_o   <= n_err;
    pending_o  <= expected_q.size();
    stored_o   <= n_stored;
    products_o <= n_prod;
    beats_o    <= n_beats;
  end

endmodule

FILE: dv/tb_top.sv
// Stimulus, flow control and verdict for the matrix multiplier testbench
module tb_top;
  import mm_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int MAX_DIM       = 8;
  localparam int ELEM_BITS     = 16;
  localparam int RANDOM_ITEMS  = 470;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 64;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int CALM_PHASES   = 6;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [DIM_BITS-1:0]     cfg_data;
  int unsigned             n_err, n_pending, n_stored, n_prod, n_beats;
  bit                      calm;
  bit                      calm_set;
  bit                      hold_req;
  logic [DIM_BITS-1:0]     cur_rows, cur_inner, cur_cols;
  int unsigned             base;
  int unsigned             phase;
  int unsigned             calm_start;

  mm_in_if #(.ELEM_BITS(ELEM_BITS)) in_ch ();
  mm_out_if                         out_ch ();

  matrix_multiply #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mm_checker #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_func_i   (in_ch.func),
    .in_elem_i   (in_ch.elem_value),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_row_i   (out_ch.out_row),
    .out_col_i   (out_ch.out_col),
    .out_value_i (out_ch.out_value),
    .out_last_i  (out_ch.out_last),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .errors_o    (n_err),
    .pending_o   (n_pending),
    .stored_o    (n_stored),
    .products_o  (n_prod),
    .beats_o     (n_beats)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off at the first result beat after hold_req is set
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && out_ch.valid) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  function automatic int unsigned span(input logic [DIM_BITS-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 8) return DIM_BITS'($urandom_range(9, 15));
    if (roll < 16) return DIM_BITS'(MAX_DIM);
    return DIM_BITS'($urandom_range(1, 4));
  endfunction

  task automatic send_elem(input logic f, input logic [ELEM_BITS-1:0] v);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.elem_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for the block to go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_dims(input logic [3:0] mask, input logic [DIM_BITS-1:0] r,
                              input logic [DIM_BITS-1:0] i, input logic [DIM_BITS-1:0] c);
    settle();
    if (mask[0]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_A_ROWS;
      cfg_data <= r;
      cur_rows = r;
      @(posedge clk);
    end
    if (mask[1]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_INNER_DIM;
      cfg_data <= i;
      cur_inner = i;
      @(posedge clk);
    end
    if (mask[2]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_B_COLS;
      cfg_data <= c;
      cur_cols = c;
      @(posedge clk);
    end
    if (mask[3]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_UNUSED;
      cfg_data <= '1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one A/B pair interleaved at random; noisy adds surplus beats, broken stops early
  task automatic load_pair(input bit noisy, input bit broken);
    int unsigned na, nb, ia, ib, sent, cut;
    na   = span(cur_rows) * span(cur_inner);
    nb   = span(cur_inner) * span(cur_cols);
    ia   = 0;
    ib   = 0;
    sent = 0;
    cut  = broken ? $urandom_range(0, na + nb - 1) : na + nb;
    while ((ia < na || ib < nb) && sent < cut) begin
      if (noisy && ((ia == na) != (ib == nb)) && $urandom_range(99) < 6) begin
        send_elem((ia == na) ? FUNC_LOAD_A : FUNC_LOAD_B, rand_elem());
      end else if (ia < na && (ib == nb || $urandom_range(1) == 0)) begin
        send_elem(FUNC_LOAD_A, rand_elem());
        ia++;
        sent++;
      end else begin
        send_elem(FUNC_LOAD_B, rand_elem());
        ib++;
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_LOAD_A;
    in_ch.elem_value = '0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_A_ROWS;
    cfg_data         = '0;
    calm             = 1'b0;
    calm_set         = 1'b0;
    calm_start       = 0;
    hold_req         = 1'b0;
    cur_rows         = RESET_DIM;
    cur_inner        = RESET_DIM;
    cur_cols         = RESET_DIM;
    rst_n            = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scalar products at the element extremes
    program_dims(4'b1111, 4'd1, 4'd1, 4'd1);
    send_elem(FUNC_LOAD_A, 16'h8000);
    send_elem(FUNC_LOAD_B, 16'h8000);
    send_elem(FUNC_LOAD_A, 16'h7FFF);
    send_elem(FUNC_LOAD_B, 16'h8000);

    // surplus beat for a complete A is dropped
    program_dims(4'b0010, 4'd1, 4'd2, 4'd1);
    send_elem(FUNC_LOAD_A, 16'h7FFF);
    send_elem(FUNC_LOAD_A, 16'h8000);
    send_elem(FUNC_LOAD_A, 16'h1234);
    send_elem(FUNC_LOAD_B, 16'h7FFF);
    send_elem(FUNC_LOAD_B, 16'h8000);

    // zero and oversized dimensions clamp
    program_dims(4'b0110, 4'd1, 4'd0, 4'd15);
    send_elem(FUNC_LOAD_A, 16'h8000);
    send_elem(FUNC_LOAD_B, 16'h8000);
    send_elem(FUNC_LOAD_B, 16'h7FFF);
    repeat (6) send_elem(FUNC_LOAD_B, rand_elem());

    // shrinking A below its loaded count completes it on the next beat
    program_dims(4'b0111, 4'd2, 4'd2, 4'd1);
    repeat (3) send_elem(FUNC_LOAD_A, rand_elem());
    repeat (2) send_elem(FUNC_LOAD_B, rand_elem());
    program_dims(4'b0001, 4'd1, 4'd2, 4'd1);
    send_elem(FUNC_LOAD_B, rand_elem());

    settle();
    base     = n_stored;
    hold_req = 1'b1;
    phase    = 0;
    while (n_stored < base + RANDOM_ITEMS) begin
      // a run of phases with no idling once a quarter of the beats are in
      if (!calm_set && n_stored >= base + RANDOM_ITEMS / 4) begin
        calm_set   = 1'b1;
        calm_start = phase;
      end
      calm = calm_set && (phase < calm_start + CALM_PHASES);
      program_dims(4'($urandom_range(1, 15)), pick_dim(), pick_dim(), pick_dim());
      // back-to-back pairs keep the sender busy while a product drains
      repeat ((phase == 0) ? 3 : $urandom_range(1, 3))
        load_pair(1'b1, $urandom_range(99) < 10);
      if ($urandom_range(99) < 5)
        repeat ($urandom_range(1, 4))
          send_elem(($urandom_range(1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B, rand_elem());
      phase++;
    end
    calm = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Stored %0d elements over %0d load phases; %0d products, %0d beats checked",
             n_stored, phase, n_prod, n_beats);
    $display("Dimensions from zero to oversize, surplus and truncated loads, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (n_err == 0 && n_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mm_pkg.sv
rtl/core/mm_intf.sv
rtl/core/mm_mem.sv
rtl/core/mm_mac.sv
rtl/core/mm_seq.sv
rtl/core/matrix_multiply.sv
dv/mm_checker.sv
dv/tb_top.sv
